FILE: hdl/i2cram_pkg.sv
// Package with the types and constants shared by the I2C register access master.
`timescale 1ns / 1ps
`default_nettype none

package i2cram_pkg;

  localparam int DATA_W = 32;
  localparam int PADDR_W = 3;

  localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'h1F;
  localparam logic [7:0] PHASE_TICKS_RESET = 8'h01;

  typedef enum logic [0:0] {
    REG_DEVICE_ADDRESS = 1'b0,
    REG_PHASE_TICKS    = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_START_A = 3'd1,
    PH_START_B = 3'd2,
    PH_BIT_HI  = 3'd3,
    PH_BIT_LO  = 3'd4,
    PH_STOP_A  = 3'd5,
    PH_STOP_B  = 3'd6,
    PH_STOP_C  = 3'd7
  } phase_t;

  typedef struct packed {
    logic       req_valid;
    logic       req_type;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic        sda_drive;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_data;
  } res_t;

  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] phase_ticks;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
  } held_t;

endpackage

`default_nettype wire

FILE: hdl/i2cram_if.sv
// Valid/ready channel interfaces for bus ticks and their results.
`timescale 1ns / 1ps
`default_nettype none

interface i2cram_req_if;
  import i2cram_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cram_res_if;
  import i2cram_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/i2cram_regs.sv
// APB configuration registers: device address and ticks per bus phase.
`timescale 1ns / 1ps
`default_nettype none

module i2cram_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [i2cram_pkg::PADDR_W-1:0] paddr,
  input  logic [i2cram_pkg::DATA_W-1:0]  pwdata,
  output logic [i2cram_pkg::DATA_W-1:0]  prdata,
  output logic                           pready,
  output i2cram_pkg::cfg_t               cfg
);
  import i2cram_pkg::*;

  reg_index_t index;
  logic       write_en;

  assign pready = 1'b1;
  assign index = reg_index_t'(paddr[2]);
  assign write_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address <= DEVICE_ADDRESS_RESET;
      cfg.phase_ticks <= PHASE_TICKS_RESET;
    end else if (write_en) begin
      unique case (index)
        REG_DEVICE_ADDRESS: cfg.device_address <= pwdata[6:0];
        REG_PHASE_TICKS:    cfg.phase_ticks <= pwdata[7:0];
        default:            cfg.phase_ticks <= cfg.phase_ticks;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_DEVICE_ADDRESS: prdata = {{(DATA_W-7){1'b0}}, cfg.device_address};
      REG_PHASE_TICKS:    prdata = {{(DATA_W-8){1'b0}}, cfg.phase_ticks};
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/i2cram_step.sv
// Bus sequencer state and the single-tick update of phase, bits and read word.
`timescale 1ns / 1ps
`default_nettype none

module i2cram_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  i2cram_pkg::req_t item,
  input  i2cram_pkg::cfg_t cfg,
  output i2cram_pkg::res_t result
);
  import i2cram_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [2:0]  byte_index, byte_index_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [7:0]  tick_count, tick_count_next;
  held_t       held_request, held_request_next;
  logic [15:0] read_word, read_word_next;
  logic [7:0]  ticks;
  logic        rd;
  logic        rx;

  function automatic logic [7:0] first_shift(input logic [2:0] bi, input held_t h,
                                             input logic [6:0] dev);
    logic [7:0] b;
    b = 8'h00;
    if (!(h.req_type && bi >= 3'd3)) begin
      case (bi)
        3'd0:    b = {dev, 1'b0};
        3'd1:    b = h.reg_addr;
        3'd2:    b = h.req_type ? {dev, 1'b1} : h.write_data;
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

  assign ticks = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;

  always_comb begin
    phase_next = phase;
    bit_count_next = bit_count;
    byte_index_next = byte_index;
    shift_reg_next = shift_reg;
    tick_count_next = tick_count;
    held_request_next = held_request;
    read_word_next = read_word;
    result.scl_level = 1'b1;
    result.sda_level = 1'b1;
    result.sda_drive = 1'b1;
    result.busy_res = 1'b0;
    result.done_res = 1'b0;

    if (phase == PH_IDLE && item.req_valid) begin
      held_request_next = '{item.req_type, item.reg_addr, item.write_data};
      byte_index_next = 3'd0;
      bit_count_next = 4'd0;
      tick_count_next = 8'd0;
      phase_next = PH_START_A;
    end

    rd = held_request_next.req_type;
    rx = rd && (byte_index_next >= 3'd3);

    if (phase_next != PH_IDLE) begin
      result.busy_res = 1'b1;
      unique case (phase_next)
        PH_START_A: begin
          result.scl_level = 1'b1;
          result.sda_level = 1'b1;
        end
        PH_START_B: begin
          result.scl_level = 1'b1;
          result.sda_level = 1'b0;
        end
        PH_BIT_HI, PH_BIT_LO: begin
          result.scl_level = (phase_next == PH_BIT_HI);
          if (bit_count_next < 4'd8) begin
            if (rx) begin
              result.sda_drive = 1'b0;
            end else begin
              result.sda_level = shift_reg_next[7];
            end
          end else if (rx) begin
            result.sda_level = (byte_index_next != 3'd3);
          end else begin
            result.sda_drive = 1'b0;
          end
        end
        PH_STOP_A: begin
          result.scl_level = 1'b0;
          result.sda_level = 1'b0;
        end
        PH_STOP_B: begin
          result.scl_level = 1'b1;
          result.sda_level = 1'b0;
        end
        default: begin
          result.scl_level = 1'b1;
          result.sda_level = 1'b1;
        end
      endcase

      tick_count_next = tick_count_next + 8'd1;
      if (tick_count_next >= ticks) begin
        tick_count_next = 8'd0;
        unique case (phase_next)
          PH_START_A: phase_next = PH_START_B;
          PH_START_B: begin
            bit_count_next = 4'd0;
            shift_reg_next = first_shift(byte_index_next, held_request_next,
                                         cfg.device_address);
            phase_next = PH_BIT_HI;
          end
          PH_BIT_HI: begin
            if (bit_count_next < 4'd8 && rx) begin
              shift_reg_next = {shift_reg_next[6:0], item.sda_in};
            end
            phase_next = PH_BIT_LO;
          end
          PH_BIT_LO: begin
            if (bit_count_next < 4'd8) begin
              if (!rx) begin
                shift_reg_next = {shift_reg_next[6:0], 1'b0};
              end
              bit_count_next = bit_count_next + 4'd1;
              phase_next = PH_BIT_HI;
            end else begin
              if (rd && byte_index_next == 3'd3) begin
                read_word_next[7:0] = shift_reg_next;
              end else if (rd && byte_index_next == 3'd4) begin
                read_word_next[15:8] = shift_reg_next;
              end
              if ((rd && (byte_index_next == 3'd1 || byte_index_next >= 3'd4)) ||
                  (!rd && byte_index_next >= 3'd2)) begin
                phase_next = PH_STOP_A;
              end else begin
                byte_index_next = byte_index_next + 3'd1;
                bit_count_next = 4'd0;
                shift_reg_next = first_shift(byte_index_next, held_request_next,
                                             cfg.device_address);
                phase_next = PH_BIT_HI;
              end
            end
          end
          PH_STOP_A: phase_next = PH_STOP_B;
          PH_STOP_B: phase_next = PH_STOP_C;
          PH_STOP_C: begin
            if (rd && byte_index_next == 3'd1) begin
              byte_index_next = 3'd2;
              phase_next = PH_START_A;
            end else begin
              phase_next = PH_IDLE;
              result.done_res = 1'b1;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end

    result.read_data = read_word_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      bit_count <= 4'd0;
      byte_index <= 3'd0;
      shift_reg <= 8'd0;
      tick_count <= 8'd0;
      held_request <= '0;
      read_word <= 16'd0;
    end else if (en) begin
      phase <= phase_next;
      bit_count <= bit_count_next;
      byte_index <= byte_index_next;
      shift_reg <= shift_reg_next;
      tick_count <= tick_count_next;
      held_request <= held_request_next;
      read_word <= read_word_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/i2c_register_access_master_core.sv
// Top level of the bit-banged I2C register access master.
//
//   Channel  Direction  Handshake          Carries
//   req      in         valid/ready        one bus tick: request fields and sampled SDA
//   res      out        valid/ready        SCL/SDA levels, drive, busy, done, read word
//   apb      in         psel/penable/...   device_address at 0x0, phase_ticks at 0x4
//
// One tick transfer is accepted every clock unless a stalled result holds the pipeline.
// The tick is registered at the input, the sequencer updates its state in one pass,
// and the result lands in the output register.
// Synchronous reset returns the bus to idle, the address to 0x1F and phase ticks to 1.
// A stalled result holds the output register; a filled input register then holds and ready drops.
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_access_master_core (
  input  logic                           clk,
  input  logic                           rst,
  i2cram_req_if.sink                     req,
  i2cram_res_if.source                   res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [i2cram_pkg::PADDR_W-1:0] paddr,
  input  logic [i2cram_pkg::DATA_W-1:0]  pwdata,
  output logic [i2cram_pkg::DATA_W-1:0]  prdata,
  output logic                           pready
);
  import i2cram_pkg::*;

  cfg_t cfg;
  logic in_valid;
  req_t in_data;
  logic step_en;
  res_t result;
  logic out_valid;
  res_t out_data;

  i2cram_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  i2cram_step u_step (
    .clk    (clk),
    .rst    (rst),
    .en     (step_en),
    .item   (in_data),
    .cfg    (cfg),
    .result (result)
  );

  assign step_en = in_valid && (!out_valid || res.ready);
  assign req.ready = !in_valid || step_en;
  assign res.valid = out_valid;
  assign res.data = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_data <= req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || res.ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/i2cram_checker.sv
// Port-level checks on the I2C register access master and their bind.
`timescale 1ns / 1ps
`default_nettype none

module i2cram_checker (
  input logic             clk,
  input logic             rst,
  input logic             res_valid,
  input logic             res_ready,
  input i2cram_pkg::res_t res_data
);
  import i2cram_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("Result changed while stalled.");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.done_res |-> res_data.busy_res)
    else $error("Done reported outside a transaction.");

  a_idle_bus: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.busy_res |->
      res_data.scl_level && res_data.sda_level && res_data.sda_drive)
    else $error("Idle bus not released high.");

  a_release: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.sda_drive |-> res_data.sda_level && res_data.busy_res)
    else $error("Released SDA reported low or outside a transaction.");

  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("Result valid right after reset.");

endmodule

bind i2c_register_access_master_core i2cram_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_data  (res.data)
);

`default_nettype wire
